[sv/ctfv_pkg.sv]
// ctfv_pkg: constants, arctangent table and shared types of the ctf value evaluator
// used by every module of the block but the port checker; depends on nothing
`timescale 1ns / 1ps
package ctfv_pkg;
   localparam int TrigIterationsDefault = 16;
   localparam int AtanTableLen = 24;
   localparam int RemWidth = 33;
   localparam int TrigWidth = 34;
   localparam int PhaseWidth = 54;
   localparam int KWidth = 31;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 31;

   localparam logic [32:0] TwoPiQ30 = 33'd6746518852;
   localparam logic [32:0] PiQ30 = 33'd3373259426;
   localparam logic [32:0] HalfPiQ30 = 33'd1686629713;
   localparam logic [29:0] TwoOverPiQ30 = 30'd683565276;
   localparam logic [29:0] CordicGainQ30 = 30'd652032874;
   localparam logic signed [15:0] CtfConstNeg07 = -16'sd11469;
   localparam logic signed [15:0] CtfMax = 16'sd16384;

   localparam logic [29:0] AtanTable [AtanTableLen] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
      30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
      30'd1023, 30'd511, 30'd255, 30'd127
   };

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrWavelengthPi = 3'd0,
      CsrSphericalTerm = 3'd1,
      CsrDefocusMean = 3'd2,
      CsrDefocusHalfDiff = 3'd3,
      CsrAstigmatismAngle = 3'd4,
      CsrPhaseOffset = 3'd5,
      CsrLowResContrast = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [30:0] wavelength_pi;
      logic [27:0] spherical_term;
      logic [27:0] defocus_mean;
      logic [27:0] defocus_half_diff;
      logic [15:0] astigmatism_angle;
      logic [16:0] phase_offset;
      logic [14:0] low_res_contrast;
   } cfg_type;

   typedef struct packed {
      logic        const_sel;
      logic [15:0] freq_squared;
   } item_side_type;
endpackage

[sv/ctfv_mod2pi.sv]
// ctfv_mod2pi: pipelined reduction of a signed q.30 angle into [0, 2pi)
// two restoring compare and subtract steps per stage; depends on ctfv_pkg
`timescale 1ns / 1ps
module ctfv_mod2pi #(
   parameter int STEPS = 4,
   parameter int W = 35,
   parameter int SW = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [W-1:0]            in_value,
   input  logic [SW-1:0]                  in_side,
   output logic                           out_valid,
   output logic [ctfv_pkg::RemWidth-1:0]  out_rem,
   output logic [SW-1:0]                  out_side
);
   import ctfv_pkg::*;

   localparam int RW = RemWidth + STEPS;
   localparam int NS = (STEPS + 1) / 2;
   localparam logic [RW-1:0] TwoPiW = RW'(TwoPiQ30);
   localparam logic [RW-1:0] Offset = TwoPiW << (STEPS - 1);

   logic          vld_ff  [NS+1];
   logic [RW-1:0] rem_ff  [NS+1];
   logic [SW-1:0] side_ff [NS+1];
   logic [RW-1:0] rem_in;

   // offset by a multiple of 2pi so the value is never negative
   assign rem_in = {{(RW-W){in_value[W-1]}}, in_value} + Offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [RW-1:0] step_in;

      always_comb begin
         step_in = rem_ff[s];
         for (int k = 0; k < 2; k++) begin
            if (STEPS - 1 - 2*s - k >= 0) begin
               if (step_in >= (TwoPiW << (STEPS - 1 - 2*s - k))) begin
                  step_in = step_in - (TwoPiW << (STEPS - 1 - 2*s - k));
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            vld_ff[s+1] <= vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= step_in;
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[NS];
   assign out_rem = rem_ff[NS][RemWidth-1:0];
   assign out_side = side_ff[NS];
endmodule

[sv/ctfv_cordic.sv]
// ctfv_cordic: pipelined rotation-mode cordic, one iteration per stage
// takes an angle in [0, 2pi) q.30 and gives cos and sin q.30; depends on ctfv_pkg
`timescale 1ns / 1ps
module ctfv_cordic #(
   parameter int ITER = ctfv_pkg::TrigIterationsDefault,
   parameter int SW = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [ctfv_pkg::RemWidth-1:0]        in_rem,
   input  logic [SW-1:0]                        in_side,
   output logic                                 out_valid,
   output logic signed [ctfv_pkg::TrigWidth-1:0] out_cos,
   output logic signed [ctfv_pkg::TrigWidth-1:0] out_sin,
   output logic [SW-1:0]                        out_side
);
   import ctfv_pkg::*;

   localparam int N = (ITER > AtanTableLen) ? AtanTableLen : ITER;
   localparam int ZW = 33;
   localparam logic signed [34:0] PiS = $signed(35'(PiQ30));
   localparam logic signed [34:0] TwoPiS = $signed(35'(TwoPiQ30));
   localparam logic signed [34:0] HalfPiS = $signed(35'(HalfPiQ30));

   logic                        vld_ff  [N+1];
   logic signed [TrigWidth-1:0] x_ff    [N+1];
   logic signed [TrigWidth-1:0] y_ff    [N+1];
   logic signed [ZW-1:0]        z_ff    [N+1];
   logic                        flip_ff [N+1];
   logic [SW-1:0]               side_ff [N+1];

   logic signed [34:0] ang_s;
   logic signed [34:0] z_in;
   logic               flip_in;

   logic                        out_vld_ff;
   logic signed [TrigWidth-1:0] cos_ff;
   logic signed [TrigWidth-1:0] sin_ff;
   logic [SW-1:0]               out_side_ff;

   // fold into [-pi/2, pi/2] and remember the half turn
   always_comb begin
      ang_s = $signed({2'b00, in_rem});
      if (ang_s >= PiS) begin
         ang_s = ang_s - TwoPiS;
      end
      z_in = ang_s;
      flip_in = 1'b0;
      if (ang_s > HalfPiS) begin
         z_in = ang_s - PiS;
         flip_in = 1'b1;
      end else if (ang_s < -HalfPiS) begin
         z_in = ang_s + PiS;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= $signed(TrigWidth'(CordicGainQ30));
         y_ff[0] <= '0;
         z_ff[0] <= z_in[ZW-1:0];
         flip_ff[0] <= flip_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [ZW-1:0] AtanStep = $signed(ZW'(AtanTable[i]));
      logic signed [TrigWidth-1:0] dx;
      logic signed [TrigWidth-1:0] dy;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - AtanStep;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + AtanStep;
            end
            flip_ff[i+1] <= flip_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= flip_ff[N] ? -x_ff[N] : x_ff[N];
         sin_ff <= flip_ff[N] ? -y_ff[N] : y_ff[N];
         out_side_ff <= side_ff[N];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_cos = cos_ff;
   assign out_sin = sin_ff;
   assign out_side = out_side_ff;
endmodule

[sv/ctfv_phase.sv]
// ctfv_phase: seven-stage datapath from the astigmatism cosine to the ctf phase
// effective defocus, aberration phase, offset and low-resolution blend; depends on ctfv_pkg
`timescale 1ns / 1ps
module ctfv_phase (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  ctfv_pkg::cfg_type                     cfg,
   input  logic [ctfv_pkg::KWidth-1:0]           k,
   input  logic                                  in_valid,
   input  logic signed [ctfv_pkg::TrigWidth-1:0] in_cos,
   input  ctfv_pkg::item_side_type               in_side,
   output logic                                  out_valid,
   output logic signed [ctfv_pkg::PhaseWidth-1:0] out_phase,
   output logic                                  out_const
);
   import ctfv_pkg::*;

   localparam logic signed [PhaseWidth-1:0] HalfPiS = $signed(PhaseWidth'(HalfPiQ30));

   logic [7:1] vld_ff;
   logic [7:1] const_ff;

   // stage 1
   logic signed [61:0] hc_ff;
   logic [43:0]        sph_ff;
   logic [46:0]        wsp_ff;
   // stage 2
   logic signed [61:0] hc_rnd;
   logic signed [31:0] hc_sh;
   logic [44:0]        sph_rnd;
   logic [47:0]        wsp_rnd;
   logic signed [33:0] inner_in;
   logic signed [33:0] inner_ff;
   logic [31:0]        ws_ff;
   // stage 3
   logic signed [66:0] prod_ff;
   // stage 4
   logic signed [66:0] prod_rnd;
   logic signed [PhaseWidth-1:0] phase_in;
   logic signed [PhaseWidth-1:0] phase4_ff;
   // stage 5
   logic signed [PhaseWidth-1:0] diff_s;
   logic [51:0]        diff_ff;
   logic signed [PhaseWidth-1:0] phase5_ff;
   // stage 6
   logic [62:0]        lo_ff;
   logic [50:0]        hi_ff;
   logic signed [PhaseWidth-1:0] phase6_ff;
   // stage 7
   logic [63:0]        lo_rnd;
   logic [PhaseWidth-1:0] blend_in;
   logic signed [PhaseWidth-1:0] phase7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         const_ff <= {const_ff[6:1], in_side.const_sel};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hc_ff <= $signed(cfg.defocus_half_diff) * in_cos;
         sph_ff <= cfg.spherical_term * in_side.freq_squared;
         wsp_ff <= cfg.wavelength_pi * in_side.freq_squared;
      end
   end

   always_comb begin
      hc_rnd = hc_ff + (62'sd1 <<< 29);
      hc_sh = hc_rnd[61:30];
      sph_rnd = {1'b0, sph_ff} + 45'd32768;
      wsp_rnd = {1'b0, wsp_ff} + 48'd32768;
      inner_in = $signed({{6{cfg.defocus_mean[27]}}, cfg.defocus_mean})
               + $signed({{2{hc_sh[31]}}, hc_sh})
               - $signed({5'b0, sph_rnd[44:16]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inner_ff <= inner_in;
         ws_ff <= wsp_rnd[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= $signed({1'b0, ws_ff}) * inner_ff;
      end
   end

   always_comb begin
      prod_rnd = prod_ff + 67'sd512;
      phase_in = $signed(prod_rnd[63:10])
               + $signed({{20{cfg.phase_offset[16]}}, cfg.phase_offset, 17'd0});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase4_ff <= phase_in;
      end
   end

   // a zero distance gives a zero blend, so no separate enable travels on
   assign diff_s = HalfPiS - phase4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         phase5_ff <= phase4_ff;
         if (cfg.low_res_contrast != '0 && phase4_ff < HalfPiS) begin
            diff_ff <= diff_s[51:0];
         end else begin
            diff_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= diff_ff[31:0] * k;
         hi_ff <= diff_ff[51:32] * k;
         phase6_ff <= phase5_ff;
      end
   end

   always_comb begin
      lo_rnd = {1'b0, lo_ff} + 64'd536870912;
      blend_in = PhaseWidth'({hi_ff, 2'b00}) + PhaseWidth'(lo_rnd[63:30]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase7_ff <= phase6_ff + $signed(blend_in);
      end
   end

   assign out_valid = vld_ff[7];
   assign out_phase = phase7_ff;
   assign out_const = const_ff[7];
endmodule

[sv/ctf_value_evaluator_unit.sv]
// ctf_value_evaluator_unit: fully pipelined contrast transfer function evaluator.
// One frequency and azimuth pair is taken every cycle while req_ready is high, and one
// q1.14 value comes out per pair, in order, through two cordic pipelines, one stage per
// iteration, and two 2pi reductions, two subtract steps per stage. The result register
// lets the pipe keep moving while a result waits; once the last stage also holds a result,
// the whole pipe holds and req_ready drops until the result transfer completes.
// Registers are to be written through the csr port only while no transfer is in flight;
// the block itself does not enforce this.
`timescale 1ns / 1ps
module ctf_value_evaluator_unit #(
   parameter int TRIG_ITERATIONS = ctfv_pkg::TrigIterationsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [15:0]                           req_freq_squared,
   input  logic signed [15:0]                    req_angle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [15:0]                    rsp_ctf_value,
   input  logic                                  csr_write,
   input  logic [ctfv_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [ctfv_pkg::CsrDataWidth-1:0]     csr_data
);
   import ctfv_pkg::*;

   localparam int AngSteps = 4;
   localparam int PhaseSteps = 22;

   cfg_type            cfg_ff;
   logic [KWidth-1:0]  k_ff;
   logic [45:0]        k_prod;

   logic               pipe_en;
   logic               load;

   logic signed [16:0] ang_diff;
   logic signed [34:0] ang_q30;
   item_side_type      in_side;

   logic                  am_valid;
   logic [RemWidth-1:0]   am_rem;
   item_side_type         am_side;

   logic                        at_valid;
   logic signed [TrigWidth-1:0] at_cos;
   item_side_type               at_side;

   logic                         ph_valid;
   logic signed [PhaseWidth-1:0] ph_value;
   logic                         ph_const;

   logic                  pm_valid;
   logic [RemWidth-1:0]   pm_rem;
   logic                  pm_const;

   logic                        ps_valid;
   logic signed [TrigWidth-1:0] ps_sin;
   logic                        ps_const;

   logic signed [34:0] neg_sin;
   logic signed [34:0] sin_rnd;
   logic signed [18:0] scaled;
   logic signed [15:0] ctf_in;

   logic               rsp_valid_ff;
   logic signed [15:0] ctf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CsrWavelengthPi:     cfg_ff.wavelength_pi <= csr_data;
            CsrSphericalTerm:    cfg_ff.spherical_term <= csr_data[27:0];
            CsrDefocusMean:      cfg_ff.defocus_mean <= csr_data[27:0];
            CsrDefocusHalfDiff:  cfg_ff.defocus_half_diff <= csr_data[27:0];
            CsrAstigmatismAngle: cfg_ff.astigmatism_angle <= csr_data[15:0];
            CsrPhaseOffset:      cfg_ff.phase_offset <= csr_data[16:0];
            CsrLowResContrast:   cfg_ff.low_res_contrast <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // blend gain, low_res_contrast * 2/pi in q.30
   assign k_prod = cfg_ff.low_res_contrast * TwoOverPiQ30 + 46'd8192;

   always_ff @(posedge clock) begin
      k_ff <= k_prod[44:14];
   end

   assign load = !rsp_valid_ff || rsp_ready;
   assign pipe_en = !ps_valid || load;
   assign req_ready = pipe_en;

   assign ang_diff = $signed({req_angle[15], req_angle})
                   - $signed({cfg_ff.astigmatism_angle[15], cfg_ff.astigmatism_angle});
   assign ang_q30 = {ang_diff, 18'd0};
   assign in_side.const_sel = (cfg_ff.defocus_mean == '0) && (cfg_ff.defocus_half_diff == '0);
   assign in_side.freq_squared = req_freq_squared;

   ctfv_mod2pi #(
      .STEPS (AngSteps),
      .W     (35),
      .SW    ($bits(item_side_type))
   ) u_ang_mod (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .in_value  (ang_q30),
      .in_side   (in_side),
      .out_valid (am_valid),
      .out_rem   (am_rem),
      .out_side  (am_side)
   );

   ctfv_cordic #(
      .ITER (TRIG_ITERATIONS),
      .SW   ($bits(item_side_type))
   ) u_ang_trig (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (am_valid),
      .in_rem    (am_rem),
      .in_side   (am_side),
      .out_valid (at_valid),
      .out_cos   (at_cos),
      .out_sin   (),
      .out_side  (at_side)
   );

   ctfv_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .cfg       (cfg_ff),
      .k         (k_ff),
      .in_valid  (at_valid),
      .in_cos    (at_cos),
      .in_side   (at_side),
      .out_valid (ph_valid),
      .out_phase (ph_value),
      .out_const (ph_const)
   );

   ctfv_mod2pi #(
      .STEPS (PhaseSteps),
      .W     (PhaseWidth),
      .SW    (1)
   ) u_phase_mod (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (ph_valid),
      .in_value  (ph_value),
      .in_side   (ph_const),
      .out_valid (pm_valid),
      .out_rem   (pm_rem),
      .out_side  (pm_const)
   );

   ctfv_cordic #(
      .ITER (TRIG_ITERATIONS),
      .SW   (1)
   ) u_phase_trig (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (pm_valid),
      .in_rem    (pm_rem),
      .in_side   (pm_const),
      .out_valid (ps_valid),
      .out_cos   (),
      .out_sin   (ps_sin),
      .out_side  (ps_const)
   );

   // -sin rounded to q1.14 and clamped, or the fixed constant when the defocus is zero
   always_comb begin
      neg_sin = -$signed({ps_sin[TrigWidth-1], ps_sin});
      sin_rnd = neg_sin + 35'sd32768;
      scaled = sin_rnd[34:16];
      if (ps_const) begin
         ctf_in = CtfConstNeg07;
      end else if (scaled > 19'sd16384) begin
         ctf_in = CtfMax;
      end else if (scaled < -19'sd16384) begin
         ctf_in = -CtfMax;
      end else begin
         ctf_in = scaled[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= ps_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && ps_valid) begin
         ctf_ff <= ctf_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ctf_value = ctf_ff;
endmodule

[sv/ctfv_checker.sv]
// ctfv_port_checker: port-level assertions for ctf_value_evaluator_unit
// bound to the top level below; depends on nothing else
`timescale 1ns / 1ps
module ctfv_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_ctf_value
);
   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ctf_value))
      else $error("stalled result changed");

   // results stay within -1..1 in q1.14
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ctf_value <= 16'sd16384) && (rsp_ctf_value >= -16'sd16384))
      else $error("result out of range");

   // input only backs up behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // nothing leaves right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind ctf_value_evaluator_unit ctfv_port_checker u_ctfv_checker (.*);
